FILE: hdl/kvmt_pkg.sv
// ----------------------------------------------------------------------------
// kvmt_pkg: shared definitions for the key/value map table
// Operation codes, default sizes and the control bundle broadcast to cells.
// ----------------------------------------------------------------------------
package kvmt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Control bundle sent from the sequencer to every slot cell.
  typedef struct packed {
    logic       exec;    // update cycle of a transaction
    logic [1:0] op;      // operation code of the transaction
    logic       no_hit;  // no slot holds the requested key
  } kvmt_ctl_t;

endpackage

FILE: hdl/kvmt_cell.sv
// ----------------------------------------------------------------------------
// kvmt_cell: one slot of the key/value map table
// Holds a key, a value and a valid bit, compares against the request key and
// passes free, hit and read-data information on to the next cell of the row.
// ----------------------------------------------------------------------------
module kvmt_cell #(
  parameter int KEY_BITS   = kvmt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvmt_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kvmt_pkg::kvmt_ctl_t     ctl,
  input  logic [KEY_BITS-1:0]     req_key,
  input  logic [VALUE_BITS-1:0]   req_value,
  input  logic                    free_in,
  output logic                    free_out,
  input  logic                    hit_in,
  output logic                    hit_out,
  input  logic [VALUE_BITS-1:0]   rd_in,
  output logic [VALUE_BITS-1:0]   rd_out
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  match;
  logic                  insert;

  assign match    = valid_r && (key_r == req_key);
  assign free_out = free_in || !valid_r;
  assign hit_out  = hit_in || match;
  assign rd_out   = rd_in | (match ? value_r : '0);

  // Only the lowest free slot takes a new pair.
  assign insert = ctl.exec && (ctl.op == kvmt_pkg::OP_ADD) && ctl.no_hit &&
                  !valid_r && !free_in;

  always_comb begin
    valid_nxt = valid_r;
    if (insert) begin
      valid_nxt = 1'b1;
    end else if (ctl.exec && match && (ctl.op == kvmt_pkg::OP_REMOVE)) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      key_r   <= req_key;
      value_r <= req_value;
    end else if (ctl.exec && match && (ctl.op == kvmt_pkg::OP_ADD)) begin
      value_r <= req_value;
    end
  end

endmodule

FILE: hdl/key_value_map_table_core.sv
// ----------------------------------------------------------------------------
// key_value_map_table_core: associative map of unique keys to values
// A row of slot cells searched in parallel, with a small sequencer on top.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction is accepted at a rising edge where start is high and
// busy is low; it carries an operation (add/update, search, remove), a key
// and, for add, a value. The request is registered on acceptance and busy is
// raised for one cycle. In that cycle every cell compares its stored key with
// the request key, the row resolves the hit, the read value and the lowest
// free slot, and the table is updated at the end of the cycle.
// The result transaction appears in the following cycle: out_valid is high
// for exactly one cycle together with the old, found or removed value, the
// hit flag, the full flag for a refused add and the new entry count.
// A new request is not accepted while busy is high, that is while the cell
// row does its compare and update. Results cannot be stalled by
// the receiver; they must be taken in the cycle they are shown.
// A synchronous reset empties the table (all valid bits cleared, count zero)
// and drops any request in flight. Stored keys and values need no reset.
// ----------------------------------------------------------------------------
module key_value_map_table_core #(
  parameter int CAPACITY   = kvmt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = kvmt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvmt_pkg::VALUE_BITS_DEF,
  parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_req_type,
  input  logic signed [KEY_BITS-1:0]   in_req_key,
  input  logic signed [VALUE_BITS-1:0] in_req_value,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_resp_value,
  output logic                         out_hit,
  output logic                         out_full_refused,
  output logic [CNT_BITS-1:0]          out_entry_count
);

  // Request registers, loaded when a transaction is accepted.
  logic                  busy_r;
  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;

  logic [CNT_BITS-1:0]   pair_count_r;
  logic [CNT_BITS-1:0]   pair_count_nxt;

  // Result registers.
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] resp_value_r;
  logic                  hit_r;
  logic                  refused_r;

  // Chains that run through the row of cells.
  logic                  free_chain [CAPACITY+1];
  logic                  hit_chain  [CAPACITY+1];
  logic [VALUE_BITS-1:0] rd_chain   [CAPACITY+1];

  kvmt_pkg::kvmt_ctl_t   ctl;
  logic                  accept;
  logic                  op_known;
  logic                  any_hit;
  logic                  table_full;
  logic                  do_insert;
  logic                  do_remove;
  logic                  refused;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign free_chain[0] = 1'b0;
  assign hit_chain[0]  = 1'b0;
  assign rd_chain[0]   = '0;

  assign any_hit    = hit_chain[CAPACITY];
  assign table_full = !free_chain[CAPACITY];

  assign ctl.exec   = busy_r;
  assign ctl.op     = op_r;
  assign ctl.no_hit = !any_hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvmt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .req_key   (key_r),
      .req_value (value_r),
      .free_in   (free_chain[i]),
      .free_out  (free_chain[i+1]),
      .hit_in    (hit_chain[i]),
      .hit_out   (hit_chain[i+1]),
      .rd_in     (rd_chain[i]),
      .rd_out    (rd_chain[i+1])
    );
  end

  // An unused operation code leaves the table alone and reports a miss.
  assign op_known  = (op_r == kvmt_pkg::OP_ADD) || (op_r == kvmt_pkg::OP_SEARCH) ||
                     (op_r == kvmt_pkg::OP_REMOVE);
  assign do_insert = (op_r == kvmt_pkg::OP_ADD) && !any_hit && !table_full;
  assign do_remove = (op_r == kvmt_pkg::OP_REMOVE) && any_hit;
  assign refused   = (op_r == kvmt_pkg::OP_ADD) && !any_hit && table_full;

  always_comb begin
    pair_count_nxt = pair_count_r;
    if (busy_r) begin
      if (do_insert) begin
        pair_count_nxt = pair_count_r + CNT_BITS'(1);
      end else if (do_remove) begin
        pair_count_nxt = pair_count_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pair_count_r <= '0;
    end else begin
      busy_r       <= accept;
      out_valid_r  <= busy_r;
      pair_count_r <= pair_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_req_type;
      key_r   <= in_req_key;
      value_r <= in_req_value;
    end
  end

  // The read chain is zero on a miss, so only the operation code gates it.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      resp_value_r <= op_known ? rd_chain[CAPACITY] : '0;
      hit_r        <= op_known && any_hit;
      refused_r    <= refused;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_resp_value   = resp_value_r;
  assign out_hit          = hit_r;
  assign out_full_refused = refused_r;
  assign out_entry_count  = pair_count_r;

endmodule

FILE: hdl/kvmt_checker.sv
// ----------------------------------------------------------------------------
// kvmt_checker: port-level checks for the key/value map table
// Watches the request and result ports over time and is bound to the core.
// ----------------------------------------------------------------------------
module kvmt_checker #(
  parameter int CAPACITY   = kvmt_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = kvmt_pkg::VALUE_BITS_DEF,
  parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [VALUE_BITS-1:0] out_resp_value,
  input logic                  out_hit,
  input logic                  out_full_refused,
  input logic [CNT_BITS-1:0]   out_entry_count
);

  // Each accepted transaction yields exactly one result, registered through busy and then out_valid.
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result missing after accepted request");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  // A refused add can only happen when the table is at capacity.
  a_refused_full : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_refused) |->
      (!out_hit && (out_entry_count == CNT_BITS'(CAPACITY)) && (out_resp_value == '0)))
    else $error("refused add with room left or with a hit");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_BITS'(CAPACITY)))
    else $error("entry count above capacity");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_resp_value == '0))
    else $error("nonzero value on a miss");

endmodule

bind key_value_map_table_core kvmt_checker #(
  .CAPACITY   (CAPACITY),
  .VALUE_BITS (VALUE_BITS),
  .CNT_BITS   (CNT_BITS)
) u_kvmt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_resp_value   (out_resp_value),
  .out_hit          (out_hit),
  .out_full_refused (out_full_refused),
  .out_entry_count  (out_entry_count)
);
